// ===== rtl/spr_pkg.sv =====
// ----------------------------------------------------------------------------
// spr_pkg: shared definitions for the game pad serial reader
// Holds field widths, phase codes, register indexes, button bit positions
// and the reset values of the configuration registers.
// ----------------------------------------------------------------------------
package spr_pkg;

	// Sequence sizes.
	localparam int CLOCK_PULSES = 16;
	localparam int PAD_BUTTONS  = 12;

	// Field widths.
	localparam int TICK_W    = 8;
	localparam int BIT_IDX_W = 5;
	localparam int BUTTONS_W = 15;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DAT_W = 8;

	// Sequencer phase codes.
	localparam logic [2:0] PH_IDLE  = 3'd0;
	localparam logic [2:0] PH_LATCH = 3'd1;
	localparam logic [2:0] PH_WAIT  = 3'd2;
	localparam logic [2:0] PH_HIGH  = 3'd3;
	localparam logic [2:0] PH_LOW   = 3'd4;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_LATCH_TICKS     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HALF_TICKS      = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_VOL_DOWN_FROM_L = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_VOL_UP_FROM_R   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_HOME_FROM_COMBO = 3'd4;

	// Configuration reset values.
	localparam logic [TICK_W-1:0] LATCH_TICKS_RST = 8'd12;
	localparam logic [TICK_W-1:0] HALF_TICKS_RST  = 8'd6;

	// Button bit positions in the result word.
	localparam int BIT_SEL   = 2;
	localparam int BIT_START = 3;
	localparam int BIT_L     = 10;
	localparam int BIT_R     = 11;
	localparam int BIT_VDOWN = 12;
	localparam int BIT_VUP   = 13;
	localparam int BIT_HOME  = 14;

endpackage

// ===== rtl/spr_in_if.sv =====
// ----------------------------------------------------------------------------
// spr_in_if: tick input channel
// Carries one timing tick with the start request, data line level and
// auxiliary button bits.
// ----------------------------------------------------------------------------
interface spr_in_if;
	logic                            valid;
	logic                            ready;
	logic                            start_req;
	logic                            data_pin;
	logic [spr_pkg::BUTTONS_W-1:0]   aux_buttons;

	modport source (output valid, output start_req, output data_pin, output aux_buttons,
		input ready);
	modport sink (input valid, input start_req, input data_pin, input aux_buttons,
		output ready);
endinterface

// ===== rtl/spr_out_if.sv =====
// ----------------------------------------------------------------------------
// spr_out_if: result output channel
// Carries the pad line levels, status flags and button word of one tick.
// ----------------------------------------------------------------------------
interface spr_out_if;
	logic                            valid;
	logic                            ready;
	logic                            clk_pin;
	logic                            latch_pin;
	logic                            busy_res;
	logic                            done_res;
	logic [spr_pkg::BUTTONS_W-1:0]   buttons;

	modport source (output valid, output clk_pin, output latch_pin, output busy_res,
		output done_res, output buttons, input ready);
	modport sink (input valid, input clk_pin, input latch_pin, input busy_res,
		input done_res, input buttons, output ready);
endinterface

// ===== rtl/spr_cfg_if.sv =====
// ----------------------------------------------------------------------------
// spr_cfg_if: configuration write channel
// Carries a register index and the data to write into it.
// ----------------------------------------------------------------------------
interface spr_cfg_if;
	logic                            valid;
	logic                            ready;
	logic [spr_pkg::CFG_IDX_W-1:0]   index;
	logic [spr_pkg::CFG_DAT_W-1:0]   data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

// ===== rtl/snes_pad_serial_reader_unit.sv =====
// ----------------------------------------------------------------------------
// snes_pad_serial_reader_unit: game pad poller over a latch/clock/data link
// Each accepted tick advances the poll sequencer by one step; the result of
// that tick is registered in the output register.
// ----------------------------------------------------------------------------
// The result of a tick is valid the cycle after the tick is accepted.
// Throughput: one tick per cycle while results are taken; the sequencer state updates in a single
// step and the output register frees as its result is taken.
// Reset: sequencer idle with both pad lines low, registers at their defaults,
// output register empty.
module snes_pad_serial_reader_unit (
	input  logic      clk,
	input  logic      arst_n,
	spr_in_if.sink    tick_in,
	spr_out_if.source res_out,
	spr_cfg_if.sink   cfg
);

	// Configuration registers.
	logic [spr_pkg::TICK_W-1:0]    latch_ticks_q;
	logic [spr_pkg::TICK_W-1:0]    half_ticks_q;
	logic                          vol_down_from_l_q;
	logic                          vol_up_from_r_q;
	logic                          home_from_combo_q;

	// Sequencer state.
	logic [2:0]                    phase_q;
	logic [spr_pkg::TICK_W-1:0]    tick_q;
	logic [spr_pkg::BIT_IDX_W-1:0] bit_q;
	logic [spr_pkg::PAD_BUTTONS-1:0] pressed_q;
	logic                          clk_lvl_q;
	logic                          latch_lvl_q;

	// Next-state values.
	logic [2:0]                    phase_n;
	logic [spr_pkg::TICK_W-1:0]    tick_n;
	logic [spr_pkg::BIT_IDX_W-1:0] bit_n;
	logic [spr_pkg::PAD_BUTTONS-1:0] pressed_n;
	logic                          clk_lvl_n;
	logic                          latch_lvl_n;
	logic                          done_n;
	logic [spr_pkg::BUTTONS_W-1:0] buttons_n;

	logic                          expired;
	logic                          sample_now;
	logic [spr_pkg::BIT_IDX_W-1:0] bit_inc;
	logic [spr_pkg::BUTTONS_W-1:0] fin;

	// Output register.
	logic                          out_valid_q;
	logic                          clk_pin_q;
	logic                          latch_pin_q;
	logic                          busy_q;
	logic                          done_q;
	logic [spr_pkg::BUTTONS_W-1:0] buttons_q;

	logic                          tick_acc;

	// Configuration writes are always taken.
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			latch_ticks_q     <= spr_pkg::LATCH_TICKS_RST;
			half_ticks_q      <= spr_pkg::HALF_TICKS_RST;
			vol_down_from_l_q <= 1'b1;
			vol_up_from_r_q   <= 1'b1;
			home_from_combo_q <= 1'b1;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				spr_pkg::REG_LATCH_TICKS:     latch_ticks_q     <= cfg.data;
				spr_pkg::REG_HALF_TICKS:      half_ticks_q      <= cfg.data;
				spr_pkg::REG_VOL_DOWN_FROM_L: vol_down_from_l_q <= cfg.data[0];
				spr_pkg::REG_VOL_UP_FROM_R:   vol_up_from_r_q   <= cfg.data[0];
				spr_pkg::REG_HOME_FROM_COMBO: home_from_combo_q <= cfg.data[0];
				default: ;
			endcase
		end
	end

	// A tick is taken whenever the output register is empty or being drained.
	assign tick_in.ready = !out_valid_q || res_out.ready;
	assign tick_acc      = tick_in.valid && tick_in.ready;

	// A phase ends on the tick its counter is at one or zero.
	assign expired = (tick_q <= spr_pkg::TICK_W'(1));
	assign bit_inc = bit_q + spr_pkg::BIT_IDX_W'(1);

	// Completion word: remaps in fixed order, then the auxiliary bits.
	always_comb begin
		fin = spr_pkg::BUTTONS_W'(pressed_q);
		if (vol_down_from_l_q && fin[spr_pkg::BIT_L]) begin
			fin[spr_pkg::BIT_VDOWN] = 1'b1;
			fin[spr_pkg::BIT_L]     = 1'b0;
		end
		if (vol_up_from_r_q && fin[spr_pkg::BIT_R]) begin
			fin[spr_pkg::BIT_VUP] = 1'b1;
			fin[spr_pkg::BIT_R]   = 1'b0;
		end
		if (home_from_combo_q && fin[spr_pkg::BIT_SEL] && fin[spr_pkg::BIT_START]) begin
			fin[spr_pkg::BIT_SEL]   = 1'b0;
			fin[spr_pkg::BIT_START] = 1'b0;
			fin[spr_pkg::BIT_HOME]  = 1'b1;
		end
		fin = fin | tick_in.aux_buttons;
	end

	// One sequencer step per tick.
	always_comb begin
		phase_n     = phase_q;
		tick_n      = tick_q;
		bit_n       = bit_q;
		pressed_n   = pressed_q;
		clk_lvl_n   = clk_lvl_q;
		latch_lvl_n = latch_lvl_q;
		done_n      = 1'b0;
		buttons_n   = '0;
		sample_now  = 1'b0;

		if (!expired && phase_q != spr_pkg::PH_IDLE) begin
			tick_n = tick_q - spr_pkg::TICK_W'(1);
		end

		unique case (phase_q)
			spr_pkg::PH_IDLE: begin
				if (tick_in.start_req) begin
					clk_lvl_n   = 1'b0;
					latch_lvl_n = 1'b1;
					pressed_n   = '0;
					bit_n       = '0;
					tick_n      = latch_ticks_q;
					phase_n     = spr_pkg::PH_LATCH;
				end
			end
			spr_pkg::PH_LATCH: begin
				if (expired) begin
					latch_lvl_n = 1'b0;
					tick_n      = half_ticks_q;
					phase_n     = spr_pkg::PH_WAIT;
				end
			end
			spr_pkg::PH_WAIT: begin
				if (expired) begin
					sample_now = 1'b1;
				end
			end
			spr_pkg::PH_HIGH: begin
				if (expired) begin
					clk_lvl_n = 1'b0;
					tick_n    = half_ticks_q;
					phase_n   = spr_pkg::PH_LOW;
				end
			end
			spr_pkg::PH_LOW: begin
				if (expired) begin
					bit_n = bit_inc;
					if (bit_inc >= spr_pkg::BIT_IDX_W'(spr_pkg::CLOCK_PULSES)) begin
						buttons_n   = fin;
						done_n      = 1'b1;
						phase_n     = spr_pkg::PH_IDLE;
						tick_n      = '0;
						bit_n       = '0;
						clk_lvl_n   = 1'b0;
						latch_lvl_n = 1'b0;
					end else begin
						sample_now = 1'b1;
					end
				end
			end
			default: begin
				phase_n     = spr_pkg::PH_IDLE;
				tick_n      = '0;
				clk_lvl_n   = 1'b0;
				latch_lvl_n = 1'b0;
			end
		endcase

		// Rising clock edge: sample the data line, low means pressed.
		if (sample_now) begin
			if (bit_n < spr_pkg::BIT_IDX_W'(spr_pkg::PAD_BUTTONS) && !tick_in.data_pin) begin
				pressed_n = pressed_n | (spr_pkg::PAD_BUTTONS'(1) << bit_n[3:0]);
			end
			clk_lvl_n = 1'b1;
			phase_n   = spr_pkg::PH_HIGH;
			tick_n    = half_ticks_q;
		end
	end

	// Sequencer state registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= spr_pkg::PH_IDLE;
			tick_q      <= '0;
			bit_q       <= '0;
			pressed_q   <= '0;
			clk_lvl_q   <= 1'b0;
			latch_lvl_q <= 1'b0;
		end else if (tick_acc) begin
			phase_q     <= phase_n;
			tick_q      <= tick_n;
			bit_q       <= bit_n;
			pressed_q   <= pressed_n;
			clk_lvl_q   <= clk_lvl_n;
			latch_lvl_q <= latch_lvl_n;
		end
	end

	// Output valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (tick_acc) begin
			out_valid_q <= 1'b1;
		end else if (res_out.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output payload, loaded with each accepted tick.
	always_ff @(posedge clk) begin
		if (tick_acc) begin
			clk_pin_q   <= clk_lvl_n;
			latch_pin_q <= latch_lvl_n;
			busy_q      <= (phase_n != spr_pkg::PH_IDLE);
			done_q      <= done_n;
			buttons_q   <= buttons_n;
		end
	end

	assign res_out.valid     = out_valid_q;
	assign res_out.clk_pin   = clk_pin_q;
	assign res_out.latch_pin = latch_pin_q;
	assign res_out.busy_res  = busy_q;
	assign res_out.done_res  = done_q;
	assign res_out.buttons   = buttons_q;

endmodule

// ===== tb/tb_snes_pad_serial_reader_unit.sv =====
// ----------------------------------------------------------------------------
// tb_snes_pad_serial_reader_unit: self-checking bench for the pad poller
// Streams timing ticks into the poller and compares every result transaction
// field by field against a tick-by-tick model of the latch/clock/data sequence,
// including the button remaps and the auxiliary bits merged at completion.
// A short table of directed ticks comes first, then random polls under
// changing register settings, with random gaps on both channels.
// ----------------------------------------------------------------------------
module tb_snes_pad_serial_reader_unit;
	timeunit 1ns;
	timeprecision 1ps;

	// One result transaction of the poller.
	typedef struct packed {
		logic                          clk_pin;
		logic                          latch_pin;
		logic                          busy_res;
		logic                          done_res;
		logic [spr_pkg::BUTTONS_W-1:0] buttons;
	} pad_result_t;

	// One row of the directed table: either a tick, repeated, or a register write.
	typedef enum logic {ROW_TICK, ROW_CFG} row_kind_t;
	typedef struct packed {
		row_kind_t                     kind;
		logic [spr_pkg::CFG_IDX_W-1:0] index;
		logic [spr_pkg::CFG_DAT_W-1:0] data;
		logic                          start;
		logic                          dpin;
		logic [spr_pkg::BUTTONS_W-1:0] aux;
		int                            reps;
		bit                            typed;
		pad_result_t                   want;
	} plan_row_t;

	localparam logic [spr_pkg::CFG_IDX_W-1:0] REG_UNUSED = 3'd5;
	localparam int STALL_LIMIT = 500;
	localparam int RANDOM_TICKS = 640;

	// Results that can be read straight off the sequence description.
	localparam pad_result_t QUIET = '0;
	localparam pad_result_t START_SEEN = '{clk_pin: 1'b0, latch_pin: 1'b1, busy_res: 1'b1,
		done_res: 1'b0, buttons: '0};
	localparam pad_result_t ALL_HELD = '{clk_pin: 1'b0, latch_pin: 1'b0, busy_res: 1'b0,
		done_res: 1'b1, buttons: 15'h73F3};

	logic clk = 1'b0;
	logic arst_n;

	spr_in_if  tick_if ();
	spr_out_if res_if ();
	spr_cfg_if cfg_if ();

	snes_pad_serial_reader_unit dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.tick_in (tick_if),
		.res_out (res_if),
		.cfg     (cfg_if)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Model copy of the registers.
	logic [spr_pkg::TICK_W-1:0] latch_len;
	logic [spr_pkg::TICK_W-1:0] half_len;
	logic                       l_to_vdown;
	logic                       r_to_vup;
	logic                       combo_to_home;

	// Model copy of the sequencer.
	logic [2:0]                      poll_phase;
	logic [spr_pkg::TICK_W-1:0]      poll_count;
	logic [spr_pkg::BIT_IDX_W-1:0]   poll_bit;
	logic [spr_pkg::PAD_BUTTONS-1:0] pressed_mask;
	logic                            clk_level;
	logic                            latch_level;

	pad_result_t tick_results_q [$];
	int          mismatches = 0;
	bit          tick_calm = 1'b0;
	bit          sink_calm = 1'b0;

	// Sample the data line ahead of a rising pad clock and start the high half.
	function automatic void raise_pad_clock(logic dpin);
		if (poll_bit < spr_pkg::PAD_BUTTONS && !dpin)
			pressed_mask[poll_bit] = 1'b1;
		clk_level  = 1'b1;
		poll_phase = spr_pkg::PH_HIGH;
		poll_count = half_len;
	endfunction

	// Advance the model by one tick and return what the poller reports for it.
	function automatic pad_result_t poll_tick(logic start, logic dpin,
			logic [spr_pkg::BUTTONS_W-1:0] aux);
		pad_result_t                   res;
		logic                          expired;
		logic [spr_pkg::BUTTONS_W-1:0] word;
		res = '0;
		expired = (poll_count <= 1);
		if (!expired && poll_phase != spr_pkg::PH_IDLE)
			poll_count = poll_count - 1'b1;
		case (poll_phase)
			spr_pkg::PH_IDLE: begin
				if (start) begin
					clk_level    = 1'b0;
					latch_level  = 1'b1;
					pressed_mask = '0;
					poll_bit     = '0;
					poll_count   = latch_len;
					poll_phase   = spr_pkg::PH_LATCH;
				end
			end
			spr_pkg::PH_LATCH: begin
				if (expired) begin
					latch_level = 1'b0;
					poll_count  = half_len;
					poll_phase  = spr_pkg::PH_WAIT;
				end
			end
			spr_pkg::PH_WAIT: begin
				if (expired)
					raise_pad_clock(dpin);
			end
			spr_pkg::PH_HIGH: begin
				if (expired) begin
					clk_level  = 1'b0;
					poll_count = half_len;
					poll_phase = spr_pkg::PH_LOW;
				end
			end
			spr_pkg::PH_LOW: begin
				if (expired) begin
					poll_bit = poll_bit + 1'b1;
					if (poll_bit >= spr_pkg::CLOCK_PULSES) begin
						// Remaps apply in a fixed order, then the auxiliary bits merge in.
						word = spr_pkg::BUTTONS_W'(pressed_mask);
						if (l_to_vdown && word[spr_pkg::BIT_L]) begin
							word[spr_pkg::BIT_VDOWN] = 1'b1;
							word[spr_pkg::BIT_L]     = 1'b0;
						end
						if (r_to_vup && word[spr_pkg::BIT_R]) begin
							word[spr_pkg::BIT_VUP] = 1'b1;
							word[spr_pkg::BIT_R]   = 1'b0;
						end
						if (combo_to_home && word[spr_pkg::BIT_SEL] &&
								word[spr_pkg::BIT_START]) begin
							word[spr_pkg::BIT_SEL]   = 1'b0;
							word[spr_pkg::BIT_START] = 1'b0;
							word[spr_pkg::BIT_HOME]  = 1'b1;
						end
						res.buttons  = word | aux;
						res.done_res = 1'b1;
						poll_phase   = spr_pkg::PH_IDLE;
						poll_count   = '0;
						poll_bit     = '0;
						clk_level    = 1'b0;
						latch_level  = 1'b0;
					end else begin
						raise_pad_clock(dpin);
					end
				end
			end
			default: begin
				poll_phase  = spr_pkg::PH_IDLE;
				poll_count  = '0;
				clk_level   = 1'b0;
				latch_level = 1'b0;
			end
		endcase
		res.clk_pin   = clk_level;
		res.latch_pin = latch_level;
		res.busy_res  = (poll_phase != spr_pkg::PH_IDLE);
		return res;
	endfunction

	function automatic void compare_field(string name, logic [spr_pkg::BUTTONS_W-1:0] want,
			logic [spr_pkg::BUTTONS_W-1:0] got);
		if (got !== want) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			mismatches++;
		end
	endfunction

	// Offer one tick after a random gap and record its expected result once taken.
	task automatic send_tick(input logic start, input logic dpin,
			input logic [spr_pkg::BUTTONS_W-1:0] aux, input bit typed,
			input pad_result_t want);
		int unsigned gap;
		pad_result_t got;
		gap = tick_calm ? 0 : $urandom_range(0, 8);
		if (gap != 0) begin
			tick_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		tick_if.valid       <= 1'b1;
		tick_if.start_req   <= start;
		tick_if.data_pin    <= dpin;
		tick_if.aux_buttons <= aux;
		do @(posedge clk); while (tick_if.ready !== 1'b1);
		got = poll_tick(start, dpin, aux);
		tick_results_q.push_back(typed ? want : got);
	endtask

	// Stop offering ticks and wait until every result has come back.
	task automatic settle();
		tick_if.valid <= 1'b0;
		while (tick_results_q.size() != 0)
			@(posedge clk);
		repeat (2) @(posedge clk);
	endtask

	// Write one register; indexes past the list leave every register unchanged.
	task automatic write_reg(input logic [spr_pkg::CFG_IDX_W-1:0] index,
			input logic [spr_pkg::CFG_DAT_W-1:0] data);
		cfg_if.valid <= 1'b1;
		cfg_if.index <= index;
		cfg_if.data  <= data;
		do @(posedge clk); while (cfg_if.ready !== 1'b1);
		cfg_if.valid <= 1'b0;
		case (index)
			spr_pkg::REG_LATCH_TICKS:     latch_len = data;
			spr_pkg::REG_HALF_TICKS:      half_len = data;
			spr_pkg::REG_VOL_DOWN_FROM_L: l_to_vdown = data[0];
			spr_pkg::REG_VOL_UP_FROM_R:   r_to_vup = data[0];
			spr_pkg::REG_HOME_FROM_COMBO: combo_to_home = data[0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	// Result side: random stalls, and every result transaction checked in order.
	always begin : result_sink
		int unsigned hold;
		pad_result_t want;
		hold = sink_calm ? 0 : $urandom_range(0, 8);
		if (hold != 0) begin
			res_if.ready <= 1'b0;
			repeat (hold) @(posedge clk);
		end
		res_if.ready <= 1'b1;
		do @(posedge clk); while (res_if.valid !== 1'b1);
		if (tick_results_q.size() == 0) begin
			$error("result transaction with no tick waiting for it");
			mismatches++;
		end else begin
			want = tick_results_q.pop_front();
			compare_field("clk_pin", spr_pkg::BUTTONS_W'(want.clk_pin),
				spr_pkg::BUTTONS_W'(res_if.clk_pin));
			compare_field("latch_pin", spr_pkg::BUTTONS_W'(want.latch_pin),
				spr_pkg::BUTTONS_W'(res_if.latch_pin));
			compare_field("busy_res", spr_pkg::BUTTONS_W'(want.busy_res),
				spr_pkg::BUTTONS_W'(res_if.busy_res));
			compare_field("done_res", spr_pkg::BUTTONS_W'(want.done_res),
				spr_pkg::BUTTONS_W'(res_if.done_res));
			compare_field("buttons", want.buttons, res_if.buttons);
		end
	end

	// Watchdog: ends the run if no channel moves a transaction for too long.
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((tick_if.valid && tick_if.ready) || (res_if.valid && res_if.ready) ||
					(cfg_if.valid && cfg_if.ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("snes_pad_serial_reader_unit verification failed");
		$finish;
	end

	initial begin : stimulus
		plan_row_t plan [9];
		int        rand_ticks;
		int        round;
		int        span;
		logic      start;
		int        pick;

		// Model state after reset.
		latch_len     = spr_pkg::LATCH_TICKS_RST;
		half_len      = spr_pkg::HALF_TICKS_RST;
		l_to_vdown    = 1'b1;
		r_to_vup      = 1'b1;
		combo_to_home = 1'b1;
		poll_phase    = spr_pkg::PH_IDLE;
		poll_count    = '0;
		poll_bit      = '0;
		pressed_mask  = '0;
		clk_level     = 1'b0;
		latch_level   = 1'b0;

		arst_n              <= 1'b0;
		tick_if.valid       <= 1'b0;
		tick_if.start_req   <= 1'b0;
		tick_if.data_pin    <= 1'b1;
		tick_if.aux_buttons <= '0;
		cfg_if.valid        <= 1'b0;
		cfg_if.index        <= '0;
		cfg_if.data         <= '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed poll at the shortest timing (zero counts act as one), every
		// button pressed, all remaps on, starts offered while busy and on the
		// completion tick, auxiliary bits masked outside completion.
		plan = '{
			'{ROW_TICK, '0, '0, 1'b0, 1'b1, '0, 1, 1'b1, QUIET},
			'{ROW_CFG, REG_UNUSED, 8'hFF, 1'b0, 1'b0, '0, 0, 1'b0, QUIET},
			'{ROW_CFG, spr_pkg::REG_LATCH_TICKS, 8'h00, 1'b0, 1'b0, '0, 0, 1'b0, QUIET},
			'{ROW_CFG, spr_pkg::REG_HALF_TICKS, 8'h00, 1'b0, 1'b0, '0, 0, 1'b0, QUIET},
			'{ROW_TICK, '0, '0, 1'b1, 1'b1, 15'h7FFF, 1, 1'b1, START_SEEN},
			'{ROW_TICK, '0, '0, 1'b1, 1'b0, 15'h7FFF, 1, 1'b0, QUIET},
			'{ROW_TICK, '0, '0, 1'b1, 1'b0, 15'h2AAA, 32, 1'b0, QUIET},
			'{ROW_TICK, '0, '0, 1'b1, 1'b1, 15'h0000, 1, 1'b1, ALL_HELD},
			'{ROW_TICK, '0, '0, 1'b0, 1'b1, 15'h7FFF, 1, 1'b1, QUIET}
		};
		foreach (plan[i]) begin
			if (plan[i].kind == ROW_CFG) begin
				settle();
				write_reg(plan[i].index, plan[i].data);
			end else begin
				repeat (plan[i].reps)
					send_tick(plan[i].start, plan[i].dpin, plan[i].aux, plan[i].typed,
						plan[i].want);
			end
		end

		// Random polls. The first round holds both counts at their maximum; the
		// second shortens them while that poll is still in flight.
		rand_ticks = 0;
		round      = 0;
		while (rand_ticks < RANDOM_TICKS) begin
			settle();
			tick_calm = ($urandom_range(0, 3) == 0);
			sink_calm = ($urandom_range(0, 3) == 0);
			if (round == 0) begin
				write_reg(spr_pkg::REG_LATCH_TICKS, 8'hFF);
				write_reg(spr_pkg::REG_HALF_TICKS, 8'hFF);
				write_reg(spr_pkg::REG_VOL_DOWN_FROM_L, 8'($urandom));
				write_reg(spr_pkg::REG_VOL_UP_FROM_R, 8'($urandom));
				write_reg(spr_pkg::REG_HOME_FROM_COMBO, 8'($urandom));
				span = 270;
			end else if (round == 1) begin
				write_reg(spr_pkg::REG_LATCH_TICKS, 8'h00);
				write_reg(spr_pkg::REG_HALF_TICKS, 8'h01);
				span = 300;
			end else begin
				if ($urandom_range(0, 1)) begin
					pick = $urandom_range(0, 19);
					if (pick < 15)
						write_reg(spr_pkg::REG_LATCH_TICKS, 8'($urandom_range(0, 4)));
					else if (pick < 19)
						write_reg(spr_pkg::REG_LATCH_TICKS, 8'($urandom_range(5, 40)));
					else
						write_reg(spr_pkg::REG_LATCH_TICKS, 8'($urandom_range(41, 255)));
				end
				if ($urandom_range(0, 1))
					write_reg(spr_pkg::REG_HALF_TICKS, ($urandom_range(0, 4) == 0) ?
						8'($urandom_range(2, 4)) : 8'($urandom_range(0, 1)));
				if ($urandom_range(0, 1))
					write_reg(spr_pkg::REG_VOL_DOWN_FROM_L, 8'($urandom));
				if ($urandom_range(0, 1))
					write_reg(spr_pkg::REG_VOL_UP_FROM_R, 8'($urandom));
				if ($urandom_range(0, 1))
					write_reg(spr_pkg::REG_HOME_FROM_COMBO, 8'($urandom));
				if ($urandom_range(0, 5) == 0)
					write_reg(REG_UNUSED + spr_pkg::CFG_IDX_W'($urandom_range(0, 2)),
						8'($urandom));
				span = $urandom_range(40, 160);
			end
			// Mostly start as soon as the poller is idle; stray starts while busy.
			repeat (span) begin
				if (poll_phase == spr_pkg::PH_IDLE)
					start = ($urandom_range(0, 3) != 0);
				else
					start = ($urandom_range(0, 3) == 0);
				send_tick(start, 1'($urandom_range(0, 1)),
					($urandom_range(0, 2) == 0) ? spr_pkg::BUTTONS_W'($urandom) : '0,
					1'b0, QUIET);
			end
			rand_ticks += span;
			round++;
		end

		settle();
		repeat (4) @(posedge clk);
		if (mismatches == 0)
			$display("snes_pad_serial_reader_unit verification clean");
		else
			$display("snes_pad_serial_reader_unit verification failed");
		$finish;
	end

endmodule
